// ===== src/hrr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrr_pkg
// Shared types and codes for the health-aware round-robin redirector: the
// request and response words, the backend table entry, verdict codes and
// register indexes.
// ----------------------------------------------------------------------------
package hrr_pkg;

   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_BACKENDS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXEMPT_GROUP_ID = 1'd1;

   localparam logic [1:0] VERDICT_PASS     = 2'd0;
   localparam logic [1:0] VERDICT_REDIRECT = 2'd1;
   localparam logic [1:0] VERDICT_DENY     = 2'd2;

   localparam logic ACTION_CONNECT = 1'b0;
   localparam logic ACTION_WRITE   = 1'b1;

   // Steps of the bit-serial cursor reduction, one per cursor bit.
   localparam logic [2:0] MOD_STEPS = 3'd5;

   typedef struct packed {
      logic        action;
      logic [63:0] caller_group;
      logic [31:0] dest_ip;
      logic [15:0] dest_port;
      logic [3:0]  entry_index;
      logic [31:0] entry_ip;
      logic [15:0] entry_port;
      logic        entry_healthy;
   } req_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [31:0] out_ip;
      logic [15:0] out_port;
   } rsp_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [15:0] port;
      logic        ok;
   } entry_type;

endpackage
`default_nettype wire

// ===== src/hrr_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrr_table
// Backend table: one synchronous memory of entries with a registered read
// port, plus a written flag per entry so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module hrr_table
   import hrr_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire entry_type                               wr_entry,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      entry_type                               rd_entry
);

   entry_type              mem [DEPTH];
   entry_type              mem_q_ff;
   logic                   valid_q_ff;
   logic [DEPTH-1:0]       valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         mem_q_ff   <= mem[rd_addr];
         valid_q_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_entry = valid_q_ff ? mem_q_ff : '0;

endmodule
`default_nettype wire

// ===== src/health_aware_round_robin_redirector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// health_aware_round_robin_redirector
// Connection redirector that spreads matching requests over healthy backends
// in round-robin order.
// ----------------------------------------------------------------------------
// One word is handled at a time. A table write, an exempt request or a request
// with no active entries goes straight to the response state. Any other
// request first takes a match pass through the single read port of the
// backend table over the first N entries, where N is active_backends clamped
// to TABLE_DEPTH. On a match, a selection pass follows; without one the
// request passes. The response state then loads the output register once it
// is free. The cursor reduction runs beside the match pass, and when the
// match pass ends first the selection pass waits for it. The table reads as
// all zero after reset through per-entry written flags, so there is no
// clearing pass. A new word is accepted while the previous response still
// waits in the output register.
// ----------------------------------------------------------------------------
module health_aware_round_robin_redirector
   import hrr_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire req_type              req_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      rsp_type              rsp_data,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MATCH  = 2'd1;
   localparam logic [1:0] ST_SELECT = 2'd2;
   localparam logic [1:0] ST_RESP   = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [4:0]  active_ff, active_in;
   logic [63:0] exempt_ff, exempt_in;
   logic [4:0]  cursor_ff, cursor_in;
   logic [4:0]  bound_ff, bound_in;
   logic [31:0] dip_ff, dip_in;
   logic [15:0] dport_ff, dport_in;
   logic [4:0]  rem_ff, rem_in;
   logic [2:0]  mod_cnt_ff, mod_cnt_in;
   logic [4:0]  scan_cnt_ff, scan_cnt_in;
   logic [4:0]  sel_idx_ff, sel_idx_in;
   logic        rd_pend_ff, rd_pend_in;
   logic [4:0]  rd_idx_ff, rd_idx_in;
   logic        hit_ff, hit_in;
   rsp_type     res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        req_fire;
   logic        out_free;
   logic [4:0]  bound_cfg;
   logic        mod_done;
   logic [2:0]  mod_bit_sel;
   logic [5:0]  mod_trial;
   logic        rd_hit;
   logic        rd_ok;
   logic [4:0]  rd_slot;
   logic [AW+4:0] rd_addr_wide;
   logic [AW+3:0] wr_addr_wide;
   logic        tbl_rd_en;
   logic        tbl_wr_en;
   logic [AW-1:0] tbl_rd_addr;
   logic [AW-1:0] tbl_wr_addr;
   entry_type   tbl_wr_entry;
   entry_type   tbl_rd_entry;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign bound_cfg = (32'(active_ff) > TABLE_DEPTH) ? 5'(TABLE_DEPTH) : active_ff;
   assign mod_done  = (mod_cnt_ff == 3'd0);

   assign rd_hit = rd_pend_ff && (tbl_rd_entry.ip == dip_ff) && (tbl_rd_entry.port == dport_ff);
   assign rd_ok  = rd_pend_ff && tbl_rd_entry.ok;

   assign rd_slot      = (state_ff == ST_SELECT) ? sel_idx_ff : scan_cnt_ff;
   assign rd_addr_wide = {{AW{1'b0}}, rd_slot};
   assign tbl_rd_addr  = rd_addr_wide[AW-1:0];
   assign wr_addr_wide = {{AW{1'b0}}, req_data.entry_index};
   assign tbl_wr_addr  = wr_addr_wide[AW-1:0];

   assign tbl_wr_entry.ip   = req_data.entry_ip;
   assign tbl_wr_entry.port = req_data.entry_port;
   assign tbl_wr_entry.ok   = req_data.entry_healthy;

   // Writes happen only in the idle state and reads only during the passes,
   // so the same entry is never read and written in overlapping cycles.
   hrr_table #(
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_wr_en),
      .wr_addr  (tbl_wr_addr),
      .wr_entry (tbl_wr_entry),
      .rd_en    (tbl_rd_en),
      .rd_addr  (tbl_rd_addr),
      .rd_entry (tbl_rd_entry)
   );

   always_comb begin
      active_in = active_ff;
      exempt_in = exempt_ff;
      if (csr_wr_en) begin
         if (csr_index == CSR_ACTIVE_BACKENDS) begin
            active_in = csr_wdata[4:0];
         end else begin
            exempt_in = csr_wdata;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      bound_in     = bound_ff;
      dip_in       = dip_ff;
      dport_in     = dport_ff;
      rem_in       = rem_ff;
      mod_cnt_in   = mod_cnt_ff;
      scan_cnt_in  = scan_cnt_ff;
      sel_idx_in   = sel_idx_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      hit_in       = hit_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      tbl_rd_en    = 1'b0;
      tbl_wr_en    = 1'b0;
      mod_bit_sel  = 3'd0;
      mod_trial    = 6'd0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Restoring remainder of the cursor by the active count, MSB first.
      if (!mod_done) begin
         mod_bit_sel = mod_cnt_ff - 3'd1;
         mod_trial   = {rem_ff, cursor_ff[mod_bit_sel]};
         if (mod_trial >= {1'b0, bound_ff}) begin
            rem_in = 5'(mod_trial - {1'b0, bound_ff});
         end else begin
            rem_in = mod_trial[4:0];
         end
         mod_cnt_in = mod_cnt_ff - 3'd1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.action == ACTION_WRITE) begin
                  tbl_wr_en = (32'(req_data.entry_index) < TABLE_DEPTH);
                  res_in    = '0;
                  state_in  = ST_RESP;
               end else if ((req_data.caller_group == exempt_ff) || (bound_cfg == 5'd0)) begin
                  res_in.verdict  = VERDICT_PASS;
                  res_in.out_ip   = req_data.dest_ip;
                  res_in.out_port = req_data.dest_port;
                  state_in        = ST_RESP;
               end else begin
                  dip_in      = req_data.dest_ip;
                  dport_in    = req_data.dest_port;
                  bound_in    = bound_cfg;
                  scan_cnt_in = 5'd0;
                  hit_in      = 1'b0;
                  rem_in      = 5'd0;
                  mod_cnt_in  = MOD_STEPS;
                  state_in    = ST_MATCH;
               end
            end
         end
         ST_MATCH: begin
            if (hit_ff || rd_hit) begin
               // The selection pass needs the reduced cursor, so a short
               // match pass waits here for the remainder to settle.
               if (mod_done) begin
                  sel_idx_in  = rem_ff;
                  scan_cnt_in = 5'd0;
                  hit_in      = 1'b0;
                  state_in    = ST_SELECT;
               end else begin
                  hit_in = 1'b1;
               end
            end else if ((scan_cnt_ff == bound_ff) && !rd_pend_ff) begin
               res_in.verdict  = VERDICT_PASS;
               res_in.out_ip   = dip_ff;
               res_in.out_port = dport_ff;
               state_in        = ST_RESP;
            end else if (scan_cnt_ff != bound_ff) begin
               tbl_rd_en   = 1'b1;
               rd_pend_in  = 1'b1;
               rd_idx_in   = scan_cnt_ff;
               scan_cnt_in = scan_cnt_ff + 5'd1;
            end
         end
         ST_SELECT: begin
            if (rd_ok) begin
               cursor_in       = rd_idx_ff + 5'd1;
               res_in.verdict  = VERDICT_REDIRECT;
               res_in.out_ip   = tbl_rd_entry.ip;
               res_in.out_port = tbl_rd_entry.port;
               state_in        = ST_RESP;
            end else if ((scan_cnt_ff == bound_ff) && !rd_pend_ff) begin
               res_in.verdict  = VERDICT_DENY;
               res_in.out_ip   = dip_ff;
               res_in.out_port = dport_ff;
               state_in        = ST_RESP;
            end else if (scan_cnt_ff != bound_ff) begin
               tbl_rd_en   = 1'b1;
               rd_pend_in  = 1'b1;
               rd_idx_in   = sel_idx_ff;
               scan_cnt_in = scan_cnt_ff + 5'd1;
               sel_idx_in  = (sel_idx_ff == bound_ff - 5'd1) ? 5'd0 : sel_idx_ff + 5'd1;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 5'd0;
         exempt_ff    <= 64'd0;
         cursor_ff    <= 5'd0;
         mod_cnt_ff   <= 3'd0;
         rd_pend_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         exempt_ff    <= exempt_in;
         cursor_ff    <= cursor_in;
         mod_cnt_ff   <= mod_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bound_ff    <= bound_in;
      dip_ff      <= dip_in;
      dport_ff    <= dport_in;
      rem_ff      <= rem_in;
      scan_cnt_ff <= scan_cnt_in;
      sel_idx_ff  <= sel_idx_in;
      rd_idx_ff   <= rd_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

// ===== src/hrr_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hrr_checker
// Port-level checks for the redirector: response handshake, one word in
// work at a time, and response accounting against accepted words.
// ----------------------------------------------------------------------------
module hrr_checker
   import hrr_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   logic [1:0] outstanding_ff;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Words accepted whose responses have not yet been taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= 2'd0;
      end else if (req_fire && !rsp_fire) begin
         outstanding_ff <= outstanding_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         outstanding_ff <= outstanding_ff - 2'd1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed or dropped while stalled");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("a second word was accepted while one is in work");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 2'd0)
      else $error("response without an accepted word");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff != 2'd3)
      else $error("more than two words outstanding");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.verdict == VERDICT_PASS) ||
                    (rsp_data.verdict == VERDICT_REDIRECT) ||
                    (rsp_data.verdict == VERDICT_DENY))
      else $error("response carries an undefined verdict");

endmodule

bind health_aware_round_robin_redirector hrr_checker u_hrr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
